>>> rtl/kci_pkg.sv
// ----------------------------------------------------------------------------
// kci_pkg
// Types and constants shared by the keyframe color interpolator modules.
// ----------------------------------------------------------------------------
package kci_pkg;

    localparam int FRAME_W = 31;
    localparam int TIME_W  = 16;
    localparam int PRIM_W  = 40;
    localparam int ENV_W   = 32;
    localparam int NUM_CH  = 9;    // prim R,G,B,A,LOD then env R,G,B,A
    localparam int CH_W    = 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_ENABLE  = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic MODE_HOLD   = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] ch_vec_t;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [PRIM_W-1:0] prim;     // R 39..32, G, B, A, LOD 7..0
        logic [ENV_W-1:0]  env;      // R 31..24 ... A 7..0
    } key_entry_t;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         key_index;
        logic [TIME_W-1:0]  key_time;
        logic [31:0]        prim_rgba;
        logic [7:0]         prim_lod;
        logic [31:0]        env_rgba;
        logic [FRAME_W-1:0] game_frame;
    } in_t;

    typedef struct packed {
        logic [7:0] out_prim_r;
        logic [7:0] out_prim_g;
        logic [7:0] out_prim_b;
        logic [7:0] out_prim_a;
        logic [7:0] out_prim_lod;
        logic [7:0] out_env_r;
        logic [7:0] out_env_g;
        logic [7:0] out_env_b;
        logic [7:0] out_env_a;
        logic       env_valid;
        logic [3:0] active_key;
    } out_t;

endpackage

>>> rtl/kci_mod.sv
// ----------------------------------------------------------------------------
// kci_mod
// Bit-serial restoring remainder: frame modulo loop length, one bit a cycle.
// ----------------------------------------------------------------------------
module kci_mod import kci_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [FRAME_W-1:0] dividend,
    input  logic [TIME_W-1:0]  divisor,
    output logic               done,
    output logic [TIME_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(FRAME_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [FRAME_W-1:0] dvd_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [TIME_W-1:0]  div_reg;

    logic [TIME_W:0] trial;
    logic [TIME_W:0] diff;
    logic            ge;

    always_comb begin
        trial = {rem_reg, dvd_reg[FRAME_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[FRAME_W-2:0], 1'b0};
            rem_reg <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        end
    end

    assign done      = done_reg;
    // zero loop length reduces every frame to 0
    assign remainder = (div_reg == '0) ? '0 : rem_reg;

endmodule

>>> rtl/kci_lerp.sv
// ----------------------------------------------------------------------------
// kci_lerp
// Nine channel lanes: multiply step, 8-step restoring divide, then signed add step.
// ----------------------------------------------------------------------------
module kci_lerp import kci_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ch_vec_t           lo_ch,
    input  ch_vec_t           hi_ch,
    input  logic [TIME_W-1:0] off,
    input  logic [TIME_W-1:0] span,
    output logic              done,
    output ch_vec_t           res_ch
);

    localparam int PROD_W = CH_W + TIME_W;
    localparam logic [3:0] MUL_STEP = 4'd0;
    localparam logic [3:0] DIV_LAST = 4'(CH_W);
    localparam logic [3:0] FIN_STEP = 4'(CH_W + 1);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [3:0] step_reg, step_next;

    ch_vec_t                         lo_reg;
    ch_vec_t                         mag_reg;
    logic [NUM_CH-1:0]               neg_reg;
    logic [TIME_W-1:0]               off_reg;
    logic [TIME_W-1:0]               span_reg;
    logic [NUM_CH-1:0][TIME_W-1:0]   rem_reg;
    ch_vec_t                         low_reg;
    ch_vec_t                         q_reg;
    ch_vec_t                         res_reg;

    logic [NUM_CH-1:0][PROD_W-1:0]   prod;
    logic [NUM_CH-1:0][TIME_W:0]     trial;
    logic [NUM_CH-1:0][TIME_W:0]     diff;
    logic [NUM_CH-1:0]               ge;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            prod[i]  = PROD_W'(mag_reg[i]) * PROD_W'(off_reg);
            trial[i] = {rem_reg[i], low_reg[i][CH_W-1]};
            diff[i]  = trial[i] - {1'b0, span_reg};
            ge[i]    = (trial[i] >= {1'b0, span_reg});
        end
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = MUL_STEP;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            if (step_reg == FIN_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // off <= span, so each quotient is at most the channel delta and fits 8 bits;
    // the upper product bits therefore start out below span
    always_ff @(posedge aclk) begin
        if (start) begin
            lo_reg   <= lo_ch;
            off_reg  <= off;
            span_reg <= span;
            for (int i = 0; i < NUM_CH; i++) begin
                neg_reg[i] <= (hi_ch[i] < lo_ch[i]);
                mag_reg[i] <= (hi_ch[i] < lo_ch[i]) ? lo_ch[i] - hi_ch[i]
                                                    : hi_ch[i] - lo_ch[i];
            end
        end else if (busy_reg) begin
            if (step_reg == MUL_STEP) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    rem_reg[i] <= prod[i][PROD_W-1:CH_W];
                    low_reg[i] <= prod[i][CH_W-1:0];
                    q_reg[i]   <= '0;
                end
            end else if (step_reg <= DIV_LAST) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    rem_reg[i] <= ge[i] ? diff[i][TIME_W-1:0] : trial[i][TIME_W-1:0];
                    low_reg[i] <= {low_reg[i][CH_W-2:0], 1'b0};
                    q_reg[i]   <= {q_reg[i][CH_W-2:0], ge[i]};
                end
            end else begin
                for (int i = 0; i < NUM_CH; i++) begin
                    res_reg[i] <= neg_reg[i] ? lo_reg[i] - q_reg[i] : lo_reg[i] + q_reg[i];
                end
            end
        end
    end

    assign done   = done_reg;
    assign res_ch = res_reg;

endmodule

>>> rtl/keyframe_color_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_color_interpolator
// Keyframe table with hold or linear color interpolation at a looped frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests. A load request (opcode 0) writes one key into the
//   key memory in the cycle it is taken and gives no result. An evaluate
//   request (opcode 1) gives one result on m_*.
//   cfg_we/cfg_index/cfg_wdata write the four control registers; write them
//   only while no evaluate is in flight.
//   Loads are taken one per cycle while no evaluate is in flight. An
//   evaluate's result shows on m_* in the same cycle that s_ready returns,
//   so the next request can be taken in that cycle. The time goes to the
//   bit-serial modulo, one key memory read per searched key (1..MAX_KEYS
//   of them, single read port), and in linear mode the multiply plus
//   8-step divide of the channel lanes.
//   s_ready is low while an evaluate is being worked on.
//   Results sit in an output register; a stalled m_ready holds it, and a
//   new request is still taken. A finished result waits until that register
//   frees up.
//   Reset clears the control registers (key_count 1, loop_length 1, hold
//   mode, env off). The key memory is not cleared; evaluate only keys that
//   were loaded.
// ----------------------------------------------------------------------------
module keyframe_color_interpolator import kci_pkg::*; #(
    parameter int MAX_KEYS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_RD0  = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_PREP = 3'd4;
    localparam logic [2:0] ST_LERP = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // control registers
    logic [4:0]        key_count_reg;
    logic [TIME_W-1:0] loop_len_reg;
    logic              interp_mode_reg;
    logic              env_en_reg;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg;

    key_entry_t        key_mem [MAX_KEYS];
    key_entry_t        rd_data_reg;
    key_entry_t        a_reg;
    key_entry_t        b_reg;
    logic [TIME_W-1:0] cur_reg;
    ch_vec_t           res_reg;

    logic             accept;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    key_entry_t       wr_entry;
    logic             mem_re;
    logic [IDX_W-1:0] rd_addr;

    logic             mod_start, mod_done;
    logic [TIME_W-1:0] mod_rem;
    logic             lerp_start, lerp_done;
    ch_vec_t          lerp_res;

    logic [CW-1:0]     cnt;
    logic [CW-1:0]     k_ext;
    logic              more_after_k;   // entry k+1 exists
    logic              more_after_k1;  // entry k+2 exists
    logic              hold_c;
    logic [TIME_W-1:0] span_c;
    logic [TIME_W-1:0] off_c;
    logic              out_load;
    logic              ld_a, ld_b, ld_res_hold, ld_res_lerp;

    function automatic ch_vec_t entry_chans(key_entry_t e);
        ch_vec_t ch;
        for (int j = 0; j < 5; j++) begin
            ch[j] = e.prim[PRIM_W-1-8*j -: 8];
        end
        for (int j = 0; j < 4; j++) begin
            ch[5+j] = e.env[ENV_W-1-8*j -: 8];
        end
        return ch;
    endfunction

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg   <= 5'd1;
            loop_len_reg    <= 16'd1;
            interp_mode_reg <= MODE_HOLD;
            env_en_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_COUNT:   key_count_reg   <= cfg_wdata[4:0];
                CFG_LOOP_LENGTH: loop_len_reg    <= cfg_wdata[TIME_W-1:0];
                CFG_INTERP_MODE: interp_mode_reg <= cfg_wdata[0];
                CFG_ENV_ENABLE:  env_en_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective key count: zero acts as one, clamp to table size
    always_comb begin
        if (key_count_reg == '0) begin
            cnt = CW'(1);
        end else if (32'(key_count_reg) > 32'(MAX_KEYS)) begin
            cnt = CW'(MAX_KEYS);
        end else begin
            cnt = CW'(key_count_reg);
        end
        k_ext         = CW'(k_reg);
        more_after_k  = (k_ext + CW'(1)) < cnt;
        more_after_k1 = (k_ext + CW'(2)) < cnt;
    end

    // ------------------------------------------------------------------
    // key memory: writes only in idle, reads only during an evaluate
    // ------------------------------------------------------------------
    assign mem_we   = accept && (s_data.opcode == OP_LOAD) &&
                      (32'(s_data.key_index) < 32'(MAX_KEYS));
    assign wr_addr  = IDX_W'(s_data.key_index);
    assign wr_entry = '{key_time: s_data.key_time,
                        prim:     {s_data.prim_rgba, s_data.prim_lod},
                        env:      s_data.env_rgba};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr] <= wr_entry;
        end
        if (mem_re) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // units
    // ------------------------------------------------------------------
    assign mod_start = accept && (s_data.opcode == OP_EVAL);

    kci_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_data.game_frame),
        .divisor   (loop_len_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        hold_c = (interp_mode_reg != MODE_LINEAR) || (b_reg.key_time <= a_reg.key_time);
        span_c = b_reg.key_time - a_reg.key_time;
        off_c  = (cur_reg > a_reg.key_time) ? cur_reg - a_reg.key_time : '0;
        if (off_c > span_c) begin
            off_c = span_c;
        end
    end

    kci_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .lo_ch   (entry_chans(a_reg)),
        .hi_ch   (entry_chans(b_reg)),
        .off     (off_c),
        .span    (span_c),
        .done    (lerp_done),
        .res_ch  (lerp_res)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        mem_re      = 1'b0;
        rd_addr     = '0;
        ld_a        = 1'b0;
        ld_b        = 1'b0;
        ld_res_hold = 1'b0;
        ld_res_lerp = 1'b0;
        lerp_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (mod_start) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    mem_re     = 1'b1;
                    rd_addr    = '0;
                    k_next     = '0;
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                ld_a = 1'b1;
                if (more_after_k) begin
                    mem_re     = 1'b1;
                    rd_addr    = IDX_W'(k_ext + CW'(1));
                    state_next = ST_SRCH;
                end else begin
                    ld_b       = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_SRCH: begin
                // read data holds entry k+1
                if (cur_reg >= rd_data_reg.key_time) begin
                    ld_a   = 1'b1;
                    k_next = IDX_W'(k_ext + CW'(1));
                    if (more_after_k1) begin
                        mem_re  = 1'b1;
                        rd_addr = IDX_W'(k_ext + CW'(2));
                    end else begin
                        // last key: next is itself
                        ld_b       = 1'b1;
                        state_next = ST_PREP;
                    end
                end else begin
                    ld_b       = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (hold_c) begin
                    ld_res_hold = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    lerp_start = 1'b1;
                    state_next = ST_LERP;
                end
            end
            ST_LERP: begin
                if (lerp_done) begin
                    ld_res_lerp = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mod_done && state_reg == ST_MOD) begin
            cur_reg <= mod_rem;
        end
        if (ld_a) begin
            a_reg <= rd_data_reg;
        end
        if (ld_b) begin
            b_reg <= rd_data_reg;
        end
        if (ld_res_hold) begin
            res_reg <= entry_chans(a_reg);
        end else if (ld_res_lerp) begin
            res_reg <= lerp_res;
        end
        if (out_load) begin
            m_data_reg.out_prim_r   <= res_reg[0];
            m_data_reg.out_prim_g   <= res_reg[1];
            m_data_reg.out_prim_b   <= res_reg[2];
            m_data_reg.out_prim_a   <= res_reg[3];
            m_data_reg.out_prim_lod <= res_reg[4];
            m_data_reg.out_env_r    <= env_en_reg ? res_reg[5] : '0;
            m_data_reg.out_env_g    <= env_en_reg ? res_reg[6] : '0;
            m_data_reg.out_env_b    <= env_en_reg ? res_reg[7] : '0;
            m_data_reg.out_env_a    <= env_en_reg ? res_reg[8] : '0;
            m_data_reg.env_valid    <= env_en_reg;
            m_data_reg.active_key   <= 4'(k_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ST_MOD)
        else $error("modulo result arrived outside its wait state");

    a_lerp_done_in_lerp: assert property (@(posedge aclk) disable iff (!aresetn)
        lerp_done |-> state_reg == ST_LERP)
        else $error("lerp result arrived outside its wait state");

    a_no_write_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !mem_re && state_reg == ST_IDLE)
        else $error("key write overlaps an evaluate");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SRCH |-> more_after_k)
        else $error("search read past the key count");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output step");

endmodule
